FILE: src/dle_pkg.sv
package dle_pkg;

  localparam int FRAME_DEPTH = 48;
  localparam int AW          = $clog2(FRAME_DEPTH);
  localparam int BYTE_W      = 8;
  localparam int CRC_W       = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  localparam logic [CRC_W-1:0]  CRC_INIT_RST = 16'hFFFF;
  localparam logic [BYTE_W-1:0] ESC_RST      = 8'h10;
  localparam logic [BYTE_W-1:0] START_RST    = 8'h02;
  localparam logic [BYTE_W-1:0] END_RST      = 8'h03;

  localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END      = 8'd3;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_CRC_ERR  = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRC_RD,
    ST_CRC_UPD,
    ST_RXLO_RD,
    ST_RXLO_CAP,
    ST_RXHI_RD,
    ST_CHECK,
    ST_PL_RD,
    ST_PL_LOAD
  } state_e;

  // CRC-16-CCITT, MSB first, one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[CRC_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: src/dle_if.sv
interface dle_in_if import dle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, rx_byte, input ready);
  modport sink   (input valid, rx_byte, output ready);
endinterface

interface dle_out_if import dle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [BYTE_W-1:0] data_byte;
  logic              last;
  logic [15:0]       good_frames;
  logic [15:0]       crc_errors;
  logic [15:0]       overflows;

  modport source (output valid, kind, data_byte, last, good_frames, crc_errors, overflows,
                  input ready);
  modport sink   (input valid, kind, data_byte, last, good_frames, crc_errors, overflows,
                  output ready);
endinterface

interface dle_cfg_if import dle_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] value;

  modport source (output valid, index, value, input ready);
  modport sink   (input valid, index, value, output ready);
endinterface

FILE: src/dle_ram.sv
module dle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/dle_stuffed_frame_receiver_crc16.sv
// Input: a received word is taken only while idle with a free output slot.
// Frame end: CRC walks the frame store, a read and an update state per payload byte
//   (registered RAM read), then reads the received CRC low and high bytes and compares.
// Output run: a store read then a load per payload word, held while the output stalls.
// Reset: counters zero, codes and CRC init to defaults, frame store is not cleared.
module dle_stuffed_frame_receiver_crc16 import dle_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  dle_in_if.sink     in_i,
  dle_out_if.source  out_o,
  dle_cfg_if.sink    cfg_i
);

  state_e state_q, state_d;

  logic [CRC_W-1:0]  crc_init_q;
  logic [BYTE_W-1:0] esc_q, start_q, end_q;

  logic          in_frame_q, in_frame_d;
  logic          esc_seen_q, esc_seen_d;
  logic [AW-1:0] fill_q, fill_d;
  logic [15:0]   good_q, good_d;
  logic [15:0]   crcerr_q, crcerr_d;
  logic [15:0]   ovf_q, ovf_d;

  logic [CRC_W-1:0]  crc_q, crc_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     plen_q, plen_d;
  logic [BYTE_W-1:0] rx_lo_q, rx_lo_d;

  logic              out_valid_q, out_valid_d;
  kind_e             kind_q, kind_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic              last_q, last_d;

  logic              we;
  logic [BYTE_W-1:0] rdata;
  logic              in_acc, out_free, crc_ok, start_check, pl_last;

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE) && out_free;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign crc_ok      = ({rdata, rx_lo_q} == crc_q);
  assign pl_last     = (ptr_q == plen_q - AW'(1));
  assign start_check = in_acc && in_frame_q && esc_seen_q && (in_i.rx_byte != esc_q) &&
                       (in_i.rx_byte == end_q) && (fill_q >= AW'(2));

  dle_ram #(.WIDTH(BYTE_W), .DEPTH(FRAME_DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (fill_q),
    .wdata_i (in_i.rx_byte),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_check) begin
          state_d = (fill_q == AW'(2)) ? ST_RXLO_RD : ST_CRC_RD;
        end
      end
      ST_CRC_RD:   state_d = ST_CRC_UPD;
      ST_CRC_UPD:  state_d = (ptr_q + AW'(1) == plen_q) ? ST_RXLO_RD : ST_CRC_RD;
      ST_RXLO_RD:  state_d = ST_RXLO_CAP;
      ST_RXLO_CAP: state_d = ST_RXHI_RD;
      ST_RXHI_RD:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (out_free) begin
          state_d = (!crc_ok || plen_q == '0) ? ST_IDLE : ST_PL_RD;
        end
      end
      ST_PL_RD:    state_d = ST_PL_LOAD;
      ST_PL_LOAD: begin
        if (out_free) begin
          state_d = pl_last ? ST_IDLE : ST_PL_RD;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_frame_d  = in_frame_q;
    esc_seen_d  = esc_seen_q;
    fill_d      = fill_q;
    good_d      = good_q;
    crcerr_d    = crcerr_q;
    ovf_d       = ovf_q;
    crc_d       = crc_q;
    ptr_d       = ptr_q;
    plen_d      = plen_q;
    rx_lo_d     = rx_lo_q;
    out_valid_d = out_valid_q && !out_o.ready;
    kind_d      = kind_q;
    data_d      = data_q;
    last_d      = last_q;
    we          = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_frame_q) begin
            if (esc_seen_q) begin
              if (in_i.rx_byte == start_q) begin
                in_frame_d = 1'b1;
                fill_d     = '0;
              end
              esc_seen_d = 1'b0;
            end else if (in_i.rx_byte == esc_q) begin
              esc_seen_d = 1'b1;
            end
          end else if (!esc_seen_q && in_i.rx_byte == esc_q) begin
            esc_seen_d = 1'b1;
          end else if (esc_seen_q && in_i.rx_byte != esc_q) begin
            // frame end or bad escape: frame closes either way
            in_frame_d = 1'b0;
            esc_seen_d = 1'b0;
            fill_d     = '0;
            if (in_i.rx_byte == end_q) begin
              if (fill_q < AW'(2)) begin
                crcerr_d    = crcerr_q + 16'd1;
                out_valid_d = 1'b1;
                kind_d      = KIND_CRC_ERR;
                data_d      = '0;
                last_d      = 1'b1;
              end else begin
                plen_d = fill_q - AW'(2);
                ptr_d  = '0;
                crc_d  = crc_init_q;
              end
            end
          end else begin
            // plain or stuffed byte
            esc_seen_d = 1'b0;
            we         = 1'b1;
            if (fill_q == AW'(FRAME_DEPTH - 1)) begin
              in_frame_d  = 1'b0;
              fill_d      = '0;
              ovf_d       = ovf_q + 16'd1;
              out_valid_d = 1'b1;
              kind_d      = KIND_OVERFLOW;
              data_d      = '0;
              last_d      = 1'b1;
            end else begin
              fill_d = fill_q + AW'(1);
            end
          end
        end
      end
      ST_CRC_UPD: begin
        crc_d = crc_byte(crc_q, rdata);
        ptr_d = ptr_q + AW'(1);
      end
      ST_RXLO_CAP: begin
        rx_lo_d = rdata;
        ptr_d   = ptr_q + AW'(1);
      end
      ST_CHECK: begin
        if (out_free) begin
          if (!crc_ok) begin
            crcerr_d    = crcerr_q + 16'd1;
            out_valid_d = 1'b1;
            kind_d      = KIND_CRC_ERR;
            data_d      = '0;
            last_d      = 1'b1;
          end else begin
            good_d = good_q + 16'd1;
            ptr_d  = '0;
            if (plen_q == '0) begin
              out_valid_d = 1'b1;
              kind_d      = KIND_EMPTY;
              data_d      = '0;
              last_d      = 1'b1;
            end
          end
        end
      end
      ST_PL_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = KIND_DATA;
          data_d      = rdata;
          last_d      = pl_last;
          ptr_d       = ptr_q + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_frame_q  <= 1'b0;
      esc_seen_q  <= 1'b0;
      fill_q      <= '0;
      good_q      <= '0;
      crcerr_q    <= '0;
      ovf_q       <= '0;
      out_valid_q <= 1'b0;
      crc_init_q  <= CRC_INIT_RST;
      esc_q       <= ESC_RST;
      start_q     <= START_RST;
      end_q       <= END_RST;
    end else begin
      state_q     <= state_d;
      in_frame_q  <= in_frame_d;
      esc_seen_q  <= esc_seen_d;
      fill_q      <= fill_d;
      good_q      <= good_d;
      crcerr_q    <= crcerr_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_CRC_INIT: crc_init_q <= cfg_i.value;
          REG_ESCAPE:   esc_q      <= cfg_i.value[BYTE_W-1:0];
          REG_START:    start_q    <= cfg_i.value[BYTE_W-1:0];
          REG_END:      end_q      <= cfg_i.value[BYTE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q   <= crc_d;
    ptr_q   <= ptr_d;
    plen_q  <= plen_d;
    rx_lo_q <= rx_lo_d;
    kind_q  <= kind_d;
    data_q  <= data_d;
    last_q  <= last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = kind_q;
  assign out_o.data_byte   = data_q;
  assign out_o.last        = last_q;
  assign out_o.good_frames = good_q;
  assign out_o.crc_errors  = crcerr_q;
  assign out_o.overflows   = ovf_q;

  a_good_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(good_q) |-> $past(state_q == ST_CHECK))
    else $error("good count moved outside CRC check");

  a_ovf_from_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(ovf_q) |-> $past(in_acc && in_frame_q))
    else $error("overflow count moved without a word in frame");

  a_crc_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CRC_RD) |-> (ptr_q < plen_q))
    else $error("CRC walk past payload");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PL_LOAD && out_free && pl_last) |=> (state_q == ST_IDLE && last_q))
    else $error("payload run did not close");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != KIND_DATA) |-> (last_q && data_q == '0))
    else $error("status word without last");

endmodule
